/* rtl/ts_pkg.sv */
// ----------------------------------------------------------------------------
// ts_pkg
// Shared types and constants for the turbulence statistics block.
// ----------------------------------------------------------------------------
package ts_pkg;

    localparam int CNT_W  = 16;
    localparam int SMP_W  = 16;
    localparam int SUM_W  = 32;
    localparam int SQ_W   = 47;
    localparam int CFG_W  = 15;

    localparam logic [CFG_W-1:0] MIN_SPEED_RST = 15'd3;

    // last iteration index of the shared divider and root unit
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd15;

    // last index of the per-axis and per-moment loops
    localparam logic [2:0] AXIS_LAST = 3'd2;
    localparam logic [2:0] JOB_LAST  = 3'd4;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REPORT = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_MUL,
        ST_ADD_ACC,
        ST_NN,
        ST_NN_SAVE,
        ST_MEAN,
        ST_MEAN_END,
        ST_MOM_PREP,
        ST_MOM_PLO,
        ST_MOM_PHI,
        ST_MOM_AB,
        ST_MOM_SGN,
        ST_MOM_DIFF,
        ST_MOM_ABS,
        ST_MOM_END,
        ST_SIG,
        ST_SIG_END,
        ST_UST,
        ST_UST_END,
        ST_SPD_A,
        ST_SPD_B,
        ST_SPD_C,
        ST_SPD_END,
        ST_TI_END,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

/* rtl/ts_if.sv */
// ----------------------------------------------------------------------------
// ts_if
// Channel interfaces of the turbulence statistics block.
// ----------------------------------------------------------------------------
interface ts_sample_if
    import ts_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic signed [SMP_W-1:0] wind_u;
    logic signed [SMP_W-1:0] wind_v;
    logic signed [SMP_W-1:0] wind_w;

    modport source (output valid, mode, wind_u, wind_v, wind_w, input ready);
    modport sink   (input valid, mode, wind_u, wind_v, wind_w, output ready);
endinterface

interface ts_stats_if
    import ts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [15:0] mean_u;
    logic signed [15:0] mean_v;
    logic signed [15:0] mean_w;
    logic [15:0]        sigma_east;
    logic [15:0]        sigma_north;
    logic [15:0]        sigma_up;
    logic signed [31:0] cov_east_up;
    logic signed [31:0] cov_north_up;
    logic [30:0]        kinetic_energy;
    logic [15:0]        friction_velocity;
    logic [15:0]        intensity;
    logic [CNT_W-1:0]   sample_count;

    modport source (
        output valid, mean_u, mean_v, mean_w, sigma_east, sigma_north, sigma_up,
               cov_east_up, cov_north_up, kinetic_energy, friction_velocity,
               intensity, sample_count,
        input  ready
    );
    modport sink (
        input  valid, mean_u, mean_v, mean_w, sigma_east, sigma_north, sigma_up,
               cov_east_up, cov_north_up, kinetic_energy, friction_velocity,
               intensity, sample_count,
        output ready
    );
endinterface

interface ts_cfg_if
    import ts_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] min_speed_for_intensity;

    modport source (output valid, min_speed_for_intensity, input ready);
    modport sink   (input valid, min_speed_for_intensity, output ready);
endinterface

/* rtl/turbulence_statistics.sv */
// Add transaction: five products pass through one multiplier, each in ADD_MUL
// then ADD_ACC. Clear and unused modes return to idle; a report with fewer than
// two samples goes straight to DONE. A full report makes up to nine passes through
// the shared 64-step radix-2 divider and up to five through the 16-step root unit.
// Reset clears all accumulators and the count and sets the speed threshold
// to 3; the result register comes up empty.
// ----------------------------------------------------------------------------
// turbulence_statistics
// Eddy covariance accumulator with a sequenced report built on one shared
// multiplier, one restoring divider and one restoring square root unit.
// ----------------------------------------------------------------------------
module turbulence_statistics
    import ts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ts_cfg_if.sink   cfg,
    ts_sample_if.sink samples,
    ts_stats_if.source stats
);

    state_t state_reg, state_next, ret_reg;

    // accumulators and configuration
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_u_reg, sum_v_reg, sum_w_reg;
    logic [SQ_W-1:0]  sq_u_reg, sq_v_reg, sq_w_reg;
    logic [SQ_W-1:0]  sp_uw_reg, sp_vw_reg;
    logic [CFG_W-1:0] min_speed_reg;

    // sample magnitudes for the add sequence
    logic [16:0] mag_u_reg, mag_v_reg, mag_w_reg;
    logic        neg_u_reg, neg_v_reg, neg_w_reg;

    logic [2:0]  idx_reg;
    logic [5:0]  iter_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_next, prod_reg;

    // moment datapath
    logic [31:0] nn_reg;
    logic [SQ_W-1:0] pmag_reg;
    logic        pneg_reg, abneg_reg, dneg_reg;
    logic [31:0] amag_reg, bmag_reg;
    logic [63:0] t_reg, ab_reg;

    // divider
    logic [63:0] dq_reg;
    logic [31:0] drem_reg, dsor_reg;
    logic [32:0] drem_sh, drem_sub;
    logic        dfit;

    // square root
    logic [31:0] sx_reg;
    logic [15:0] sroot_reg;
    logic [19:0] srem_reg, srem_sh, strial;
    logic        sfit;

    // statistics
    logic [16:0] mmag_u_reg, mmag_v_reg, mmag_w_reg;
    logic        mneg_u_reg, mneg_v_reg, mneg_w_reg;
    logic [31:0] var_u_reg, var_v_reg, var_w_reg;
    logic [31:0] cov_uw_reg, cov_vw_reg;
    logic [15:0] sig_u_reg, sig_v_reg, sig_w_reg;
    logic [15:0] ustar_reg, ti_reg;
    logic [31:0] spd_sq_reg;
    logic [33:0] ke_sum;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_mean_u_reg, out_mean_v_reg, out_mean_w_reg;
    logic [15:0] out_sig_u_reg, out_sig_v_reg, out_sig_w_reg;
    logic [31:0] out_cov_uw_reg, out_cov_vw_reg;
    logic [30:0] out_ke_reg;
    logic [15:0] out_ustar_reg, out_ti_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic        accept_in, count_full, few_samples;
    logic [31:0] mean_sum_sel, sig_var_sel;
    logic [SQ_W-1:0] job_p;
    logic [31:0] job_a, job_b;
    logic        job_cross;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == ST_IDLE) && (!out_valid_reg || stats.ready);
    assign accept_in     = samples.valid && samples.ready;
    assign count_full    = (count_reg == {CNT_W{1'b1}});
    assign few_samples   = (count_reg < CNT_W'(2));

    // drive result channel
    assign stats.valid             = out_valid_reg;
    assign stats.mean_u            = out_mean_u_reg;
    assign stats.mean_v            = out_mean_v_reg;
    assign stats.mean_w            = out_mean_w_reg;
    assign stats.sigma_east        = out_sig_u_reg;
    assign stats.sigma_north       = out_sig_v_reg;
    assign stats.sigma_up          = out_sig_w_reg;
    assign stats.cov_east_up       = out_cov_uw_reg;
    assign stats.cov_north_up      = out_cov_vw_reg;
    assign stats.kinetic_energy    = out_ke_reg;
    assign stats.friction_velocity = out_ustar_reg;
    assign stats.intensity         = out_ti_reg;
    assign stats.sample_count      = out_count_reg;

    // divider and root step logic
    assign drem_sh  = {drem_reg, dq_reg[63]};
    assign drem_sub = drem_sh - {1'b0, dsor_reg};
    assign dfit     = (drem_sh >= {1'b0, dsor_reg});
    assign srem_sh  = {srem_reg[17:0], sx_reg[31:30]};
    assign strial   = {2'b00, sroot_reg, 2'b01};
    assign sfit     = (srem_sh >= strial);

    assign ke_sum = {2'b00, var_u_reg} + {2'b00, var_v_reg} + {2'b00, var_w_reg};

    // select operands of the per-axis and per-moment loops
    always_comb
    begin
        case (idx_reg)
            3'd0:    mean_sum_sel = sum_u_reg;
            3'd1:    mean_sum_sel = sum_v_reg;
            default: mean_sum_sel = sum_w_reg;
        endcase
        case (idx_reg)
            3'd0:    sig_var_sel = var_u_reg;
            3'd1:    sig_var_sel = var_v_reg;
            default: sig_var_sel = var_w_reg;
        endcase
        job_cross = 1'b0;
        case (idx_reg)
            3'd0:
            begin
                job_p = sq_u_reg;  job_a = sum_u_reg; job_b = sum_u_reg;
            end
            3'd1:
            begin
                job_p = sq_v_reg;  job_a = sum_v_reg; job_b = sum_v_reg;
            end
            3'd2:
            begin
                job_p = sq_w_reg;  job_a = sum_w_reg; job_b = sum_w_reg;
            end
            3'd3:
            begin
                job_p = sp_uw_reg; job_a = sum_u_reg; job_b = sum_w_reg;
                job_cross = 1'b1;
            end
            default:
            begin
                job_p = sp_vw_reg; job_a = sum_v_reg; job_b = sum_w_reg;
                job_cross = 1'b1;
            end
        endcase
    end

    // route operands to the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ADD_MUL:
            begin
                case (idx_reg)
                    3'd0:    begin mul_a = {15'd0, mag_u_reg}; mul_b = {15'd0, mag_u_reg}; end
                    3'd1:    begin mul_a = {15'd0, mag_v_reg}; mul_b = {15'd0, mag_v_reg}; end
                    3'd2:    begin mul_a = {15'd0, mag_w_reg}; mul_b = {15'd0, mag_w_reg}; end
                    3'd3:    begin mul_a = {15'd0, mag_u_reg}; mul_b = {15'd0, mag_w_reg}; end
                    default: begin mul_a = {15'd0, mag_v_reg}; mul_b = {15'd0, mag_w_reg}; end
                endcase
            end
            ST_NN:
            begin
                mul_a = {16'd0, count_reg};
                mul_b = {16'd0, count_reg};
            end
            ST_MOM_PLO:
            begin
                mul_a = {16'd0, count_reg};
                mul_b = pmag_reg[31:0];
            end
            ST_MOM_PHI:
            begin
                mul_a = {16'd0, count_reg};
                mul_b = {17'd0, pmag_reg[46:32]};
            end
            ST_MOM_AB:
            begin
                mul_a = amag_reg;
                mul_b = bmag_reg;
            end
            ST_SPD_A:
            begin
                mul_a = {15'd0, mmag_u_reg};
                mul_b = {15'd0, mmag_u_reg};
            end
            ST_SPD_B:
            begin
                mul_a = {15'd0, mmag_v_reg};
                mul_b = {15'd0, mmag_v_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    case (mode_t'(samples.mode))
                        MODE_ADD:    state_next = count_full ? ST_IDLE : ST_ADD_MUL;
                        MODE_REPORT: state_next = few_samples ? ST_DONE : ST_NN;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_MUL:  state_next = ST_ADD_ACC;
            ST_ADD_ACC:  state_next = (idx_reg == JOB_LAST) ? ST_IDLE : ST_ADD_MUL;
            ST_NN:       state_next = ST_NN_SAVE;
            ST_NN_SAVE:  state_next = ST_MEAN;
            ST_MEAN:     state_next = ST_DIV;
            ST_MEAN_END: state_next = (idx_reg == AXIS_LAST) ? ST_MOM_PREP : ST_MEAN;
            ST_MOM_PREP: state_next = ST_MOM_PLO;
            ST_MOM_PLO:  state_next = ST_MOM_PHI;
            ST_MOM_PHI:  state_next = ST_MOM_AB;
            ST_MOM_AB:   state_next = ST_MOM_SGN;
            ST_MOM_SGN:  state_next = ST_MOM_DIFF;
            ST_MOM_DIFF: state_next = ST_MOM_ABS;
            ST_MOM_ABS:  state_next = ST_DIV;
            ST_MOM_END:  state_next = (idx_reg == JOB_LAST) ? ST_SIG : ST_MOM_PREP;
            ST_SIG:      state_next = ST_SQRT;
            ST_SIG_END:  state_next = (idx_reg == AXIS_LAST) ? ST_UST : ST_SIG;
            ST_UST:      state_next = cov_uw_reg[31] ? ST_SQRT : ST_SPD_A;
            ST_UST_END:  state_next = ST_SPD_A;
            ST_SPD_A:    state_next = ST_SPD_B;
            ST_SPD_B:    state_next = ST_SPD_C;
            ST_SPD_C:    state_next = ST_SQRT;
            ST_SPD_END:
            begin
                if ((sroot_reg != 16'd0) && (sroot_reg >= {1'b0, min_speed_reg}))
                    state_next = ST_DIV;
                else
                    state_next = ST_DONE;
            end
            ST_TI_END:   state_next = ST_DONE;
            ST_DIV:      state_next = (iter_reg == 6'd0) ? ret_reg : ST_DIV;
            ST_SQRT:     state_next = (iter_reg == 6'd0) ? ret_reg : ST_SQRT;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_u_reg     <= '0;
            sum_v_reg     <= '0;
            sum_w_reg     <= '0;
            sq_u_reg      <= '0;
            sq_v_reg      <= '0;
            sq_w_reg      <= '0;
            sp_uw_reg     <= '0;
            sp_vw_reg     <= '0;
            min_speed_reg <= MIN_SPEED_RST;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            iter_reg      <= '0;
            ret_reg       <= ST_IDLE;
        end
        else
        begin
            // take configuration writes
            if (cfg.valid)
                min_speed_reg <= cfg.min_speed_for_intensity;

            // hold result until taken
            if (stats.valid && stats.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        idx_reg <= '0;
                        case (mode_t'(samples.mode))
                            MODE_ADD:
                            begin
                                if (!count_full)
                                begin
                                    sum_u_reg <= sum_u_reg + {{16{samples.wind_u[15]}},
                                                              samples.wind_u};
                                    sum_v_reg <= sum_v_reg + {{16{samples.wind_v[15]}},
                                                              samples.wind_v};
                                    sum_w_reg <= sum_w_reg + {{16{samples.wind_w[15]}},
                                                              samples.wind_w};
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            MODE_CLEAR:
                            begin
                                count_reg <= '0;
                                sum_u_reg <= '0;
                                sum_v_reg <= '0;
                                sum_w_reg <= '0;
                                sq_u_reg  <= '0;
                                sq_v_reg  <= '0;
                                sq_w_reg  <= '0;
                                sp_uw_reg <= '0;
                                sp_vw_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_ADD_ACC:
                begin
                    case (idx_reg)
                        3'd0: sq_u_reg <= sq_u_reg + prod_reg[SQ_W-1:0];
                        3'd1: sq_v_reg <= sq_v_reg + prod_reg[SQ_W-1:0];
                        3'd2: sq_w_reg <= sq_w_reg + prod_reg[SQ_W-1:0];
                        3'd3: sp_uw_reg <= (neg_u_reg ^ neg_w_reg)
                                         ? sp_uw_reg - prod_reg[SQ_W-1:0]
                                         : sp_uw_reg + prod_reg[SQ_W-1:0];
                        default: sp_vw_reg <= (neg_v_reg ^ neg_w_reg)
                                            ? sp_vw_reg - prod_reg[SQ_W-1:0]
                                            : sp_vw_reg + prod_reg[SQ_W-1:0];
                    endcase
                    idx_reg <= idx_reg + 3'd1;
                end
                ST_MEAN:
                begin
                    iter_reg <= DIV_LAST;
                    ret_reg  <= ST_MEAN_END;
                end
                ST_MEAN_END: idx_reg <= (idx_reg == AXIS_LAST) ? 3'd0 : idx_reg + 3'd1;
                ST_MOM_ABS:
                begin
                    iter_reg <= DIV_LAST;
                    ret_reg  <= ST_MOM_END;
                end
                ST_MOM_END:  idx_reg <= (idx_reg == JOB_LAST) ? 3'd0 : idx_reg + 3'd1;
                ST_SIG:
                begin
                    iter_reg <= SQRT_LAST;
                    ret_reg  <= ST_SIG_END;
                end
                ST_SIG_END:  idx_reg <= (idx_reg == AXIS_LAST) ? 3'd0 : idx_reg + 3'd1;
                ST_UST:
                begin
                    iter_reg <= SQRT_LAST;
                    ret_reg  <= ST_UST_END;
                end
                ST_SPD_C:
                begin
                    iter_reg <= SQRT_LAST;
                    ret_reg  <= ST_SPD_END;
                end
                ST_SPD_END:
                begin
                    iter_reg <= DIV_LAST;
                    ret_reg  <= ST_TI_END;
                end
                ST_DIV:  iter_reg <= iter_reg - 6'd1;
                ST_SQRT: iter_reg <= iter_reg - 6'd1;
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            ST_IDLE:
            begin
                // split the sample into magnitude and sign
                if (accept_in)
                begin
                    mag_u_reg <= samples.wind_u[15] ? 17'd0 - {1'b1, samples.wind_u}
                                                    : {1'b0, samples.wind_u};
                    mag_v_reg <= samples.wind_v[15] ? 17'd0 - {1'b1, samples.wind_v}
                                                    : {1'b0, samples.wind_v};
                    mag_w_reg <= samples.wind_w[15] ? 17'd0 - {1'b1, samples.wind_w}
                                                    : {1'b0, samples.wind_w};
                    neg_u_reg <= samples.wind_u[15];
                    neg_v_reg <= samples.wind_v[15];
                    neg_w_reg <= samples.wind_w[15];
                end
            end
            ST_NN_SAVE: nn_reg <= prod_reg[31:0];
            ST_MEAN:
            begin
                dq_reg   <= {32'd0, mean_sum_sel[31] ? 32'd0 - mean_sum_sel : mean_sum_sel};
                drem_reg <= '0;
                dsor_reg <= {16'd0, count_reg};
            end
            ST_MEAN_END:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        mmag_u_reg <= dq_reg[16:0];
                        mneg_u_reg <= mean_sum_sel[31];
                    end
                    3'd1:
                    begin
                        mmag_v_reg <= dq_reg[16:0];
                        mneg_v_reg <= mean_sum_sel[31];
                    end
                    default:
                    begin
                        mmag_w_reg <= dq_reg[16:0];
                        mneg_w_reg <= mean_sum_sel[31];
                    end
                endcase
            end
            ST_MOM_PREP:
            begin
                pneg_reg  <= job_cross & job_p[SQ_W-1];
                pmag_reg  <= (job_cross & job_p[SQ_W-1]) ? SQ_W'(0) - job_p : job_p;
                amag_reg  <= job_a[31] ? 32'd0 - job_a : job_a;
                bmag_reg  <= job_b[31] ? 32'd0 - job_b : job_b;
                abneg_reg <= job_a[31] ^ job_b[31];
            end
            ST_MOM_PHI: t_reg <= prod_reg;
            ST_MOM_AB:  t_reg <= t_reg + {prod_reg[31:0], 32'd0};
            ST_MOM_SGN:
            begin
                t_reg  <= pneg_reg ? 64'd0 - t_reg : t_reg;
                ab_reg <= abneg_reg ? 64'd0 - prod_reg : prod_reg;
            end
            ST_MOM_DIFF: t_reg <= t_reg - ab_reg;
            ST_MOM_ABS:
            begin
                // clamp negative variance, keep sign of covariance
                dneg_reg <= t_reg[63];
                if (!t_reg[63])
                    dq_reg <= t_reg;
                else if (idx_reg <= AXIS_LAST)
                    dq_reg <= '0;
                else
                    dq_reg <= 64'd0 - t_reg;
                drem_reg <= '0;
                dsor_reg <= nn_reg;
            end
            ST_MOM_END:
            begin
                case (idx_reg)
                    3'd0:    var_u_reg  <= dq_reg[31:0];
                    3'd1:    var_v_reg  <= dq_reg[31:0];
                    3'd2:    var_w_reg  <= dq_reg[31:0];
                    3'd3:    cov_uw_reg <= dneg_reg ? 32'd0 - dq_reg[31:0] : dq_reg[31:0];
                    default: cov_vw_reg <= dneg_reg ? 32'd0 - dq_reg[31:0] : dq_reg[31:0];
                endcase
            end
            ST_SIG:
            begin
                sx_reg    <= sig_var_sel;
                sroot_reg <= '0;
                srem_reg  <= '0;
            end
            ST_SIG_END:
            begin
                case (idx_reg)
                    3'd0:    sig_u_reg <= sroot_reg;
                    3'd1:    sig_v_reg <= sroot_reg;
                    default: sig_w_reg <= sroot_reg;
                endcase
            end
            ST_UST:
            begin
                ustar_reg <= '0;
                sx_reg    <= 32'd0 - cov_uw_reg;
                sroot_reg <= '0;
                srem_reg  <= '0;
            end
            ST_UST_END: ustar_reg <= sroot_reg;
            ST_SPD_B:   spd_sq_reg <= prod_reg[31:0];
            ST_SPD_C:
            begin
                sx_reg    <= spd_sq_reg + prod_reg[31:0];
                sroot_reg <= '0;
                srem_reg  <= '0;
            end
            ST_SPD_END:
            begin
                ti_reg   <= '0;
                dq_reg   <= {40'd0, sig_u_reg, 8'd0};
                drem_reg <= '0;
                dsor_reg <= {16'd0, sroot_reg};
            end
            ST_TI_END: ti_reg <= (dq_reg[63:16] != 48'd0) ? 16'hFFFF : dq_reg[15:0];
            ST_DIV:
            begin
                // one quotient bit per cycle
                dq_reg   <= {dq_reg[62:0], dfit};
                drem_reg <= dfit ? drem_sub[31:0] : drem_sh[31:0];
            end
            ST_SQRT:
            begin
                // one root bit per cycle
                sx_reg    <= {sx_reg[29:0], 2'b00};
                srem_reg  <= sfit ? srem_sh - strial : srem_sh;
                sroot_reg <= {sroot_reg[14:0], sfit};
            end
            ST_DONE:
            begin
                out_count_reg <= count_reg;
                if (few_samples)
                begin
                    out_mean_u_reg <= '0;
                    out_mean_v_reg <= '0;
                    out_mean_w_reg <= '0;
                    out_sig_u_reg  <= '0;
                    out_sig_v_reg  <= '0;
                    out_sig_w_reg  <= '0;
                    out_cov_uw_reg <= '0;
                    out_cov_vw_reg <= '0;
                    out_ke_reg     <= '0;
                    out_ustar_reg  <= '0;
                    out_ti_reg     <= '0;
                end
                else
                begin
                    out_mean_u_reg <= mneg_u_reg ? 16'd0 - mmag_u_reg[15:0] : mmag_u_reg[15:0];
                    out_mean_v_reg <= mneg_v_reg ? 16'd0 - mmag_v_reg[15:0] : mmag_v_reg[15:0];
                    out_mean_w_reg <= mneg_w_reg ? 16'd0 - mmag_w_reg[15:0] : mmag_w_reg[15:0];
                    out_sig_u_reg  <= sig_u_reg;
                    out_sig_v_reg  <= sig_v_reg;
                    out_sig_w_reg  <= sig_w_reg;
                    out_cov_uw_reg <= cov_uw_reg;
                    out_cov_vw_reg <= cov_vw_reg;
                    out_ke_reg     <= ke_sum[31:1];
                    out_ustar_reg  <= ustar_reg;
                    out_ti_reg     <= ti_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
